>>> design/mpq_pkg.sv
// Package for the min priority queue: widths, opcodes, status codes, entry type.
// No dependencies.
`default_nettype none
package mpq_pkg;
    localparam int Depth = 1024;
    localparam int AddrW = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);
    localparam int CapW  = 11;

    localparam logic [1:0] OpInsert = 2'd0;
    localparam logic [1:0] OpRemove = 2'd1;
    localparam logic [1:0] OpPeek   = 2'd2;
    localparam logic [1:0] OpClear  = 2'd3;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StFull  = 2'd1;
    localparam logic [1:0] StEmpty = 2'd2;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] prio;
        logic [31:0] stamp;
    } t_entry;

    localparam int EntryW = $bits(t_entry);

    function automatic logic comes_first(input t_entry a, input t_entry b);
        if (a.prio != b.prio) begin
            return $signed(a.prio) < $signed(b.prio);
        end
        return a.stamp < b.stamp;
    endfunction
endpackage
`default_nettype wire

>>> design/min_priority_queue_fifo_ties.sv
// Top level of the min priority queue: heap sequencer over one entry RAM.
// Depends on mpq_pkg and mpq_ram.
//
//  channel | signals                                   | dir
//  in      | i_valid/o_ready, operation,key,prio       | in
//  out     | o_valid/i_ready, status,head_*            | out
//  cfg     | i_cfg_we, i_cfg_data (capacity)           | in
//
// One RAM read per cycle; a level climbed passes SUpRd, SUpCmp, one descended SDnL,
// SDnR, SDnCmp. Insert climbs up to log2(Depth) = 10 levels, remove descends up to
// log2(Depth)-1 = 9; every op ends in SHdRd, SHdWait. Head read from RAM slot 0.
// Synchronous reset clears state, count, stamp and o_valid and sets capacity to 1024.
// Output register holds a beat until taken; o_ready rises the cycle after that.
`default_nettype none
module min_priority_queue_fifo_ties (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_key,
    input  wire logic [31:0] i_priority_req,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [1:0]  o_status,
    output logic             o_head_valid,
    output logic      [31:0] o_head_key,
    output logic      [31:0] o_head_priority
);
    localparam logic [3:0] SIdle = 4'd0, SUpRd = 4'd1, SUpCmp = 4'd2,
        SRmRd = 4'd3, SRmLast = 4'd4, SDnL = 4'd5, SDnR = 4'd6, SDnCmp = 4'd7,
        SHdRd = 4'd8, SHdWait = 4'd9, SOut = 4'd10;
    localparam int AW = mpq_pkg::AddrW;
    localparam int CW = mpq_pkg::CntW;

    logic [3:0] r_state;
    logic [CW-1:0] r_count;
    logic [31:0] r_stamp;
    logic [10:0] r_cap;
    logic [AW-1:0] r_pos;
    mpq_pkg::t_entry r_cur, r_left;
    logic r_has_l, r_has_r;
    logic [1:0] r_status;

    logic we;
    logic [AW-1:0] waddr, raddr;
    mpq_pkg::t_entry wdata, rdata;

    mpq_ram #(.Width(mpq_pkg::EntryW), .Dep(mpq_pkg::Depth)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [CW-1:0] limit;
    assign limit = ({1'b0, r_cap} > 12'(mpq_pkg::Depth)) ? CW'(mpq_pkg::Depth)
                                                           : CW'(r_cap);
    logic [AW-1:0] up_pos, l_pos, r_pos_c;
    assign up_pos  = AW'((r_pos - AW'(1)) >> 1);
    logic [CW:0] l_full, r_full;
    assign l_full  = (CW+1)'({r_pos, 1'b1});
    assign r_full  = (CW+1)'({r_pos, 1'b1}) + (CW+1)'(1);
    assign l_pos   = AW'(l_full);
    assign r_pos_c = AW'(r_full);
    logic l_ok, r_ok;
    assign l_ok = l_full < (CW+1)'(r_count);
    assign r_ok = r_full < (CW+1)'(r_count);

    // on equal priority the older stamp wins; left wins only a full tie against right
    logic dn_l_first, dn_take_r, dn_take_l;
    assign dn_l_first = r_has_l && mpq_pkg::comes_first(r_left, r_cur);
    assign dn_take_r  = r_has_r && (dn_l_first ? mpq_pkg::comes_first(rdata, r_left)
                                               : mpq_pkg::comes_first(rdata, r_cur));
    assign dn_take_l  = dn_l_first && !dn_take_r;

    logic acc;
    assign o_ready = (r_state == SIdle);
    assign acc = i_valid && o_ready;

    always_comb begin
        we = 1'b0; waddr = r_pos; wdata = r_cur; raddr = r_pos;
        unique case (r_state)
            SUpRd:   raddr = up_pos;
            SRmRd:   raddr = AW'(r_count);
            SDnL:    raddr = l_pos;
            SDnR:    raddr = r_pos_c;
            SHdRd:   raddr = '0;
            SUpCmp: begin
                if (r_pos != '0 && mpq_pkg::comes_first(r_cur, rdata)) begin
                    we = 1'b1; wdata = rdata;
                end else begin
                    we = 1'b1;
                end
            end
            SDnCmp: begin
                we = 1'b1;
            end
            default: ;
        endcase
        if (r_state == SDnCmp) begin
            if (dn_take_r) begin
                wdata = rdata;
            end else if (dn_take_l) begin
                wdata = r_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SIdle; r_count <= '0; r_stamp <= '0;
            r_cap <= 11'd1024; o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            unique case (r_state)
                SIdle: if (acc) begin
                    r_status <= mpq_pkg::StOk;
                    r_state <= SHdRd;
                    case (i_operation)
                        mpq_pkg::OpInsert: begin
                            if (r_stamp != 32'hFFFF_FFFF) r_stamp <= r_stamp + 32'd1;
                            if (r_count >= limit) begin
                                r_status <= mpq_pkg::StFull;
                            end else begin
                                r_cur <= '{key: i_key, prio: i_priority_req, stamp: r_stamp};
                                r_pos <= AW'(r_count);
                                r_count <= r_count + CW'(1);
                                r_state <= SUpRd;
                            end
                        end
                        mpq_pkg::OpRemove: begin
                            if (r_count == '0) r_status <= mpq_pkg::StEmpty;
                            else begin
                                r_count <= r_count - CW'(1);
                                r_state <= SRmRd;
                            end
                        end
                        mpq_pkg::OpPeek:
                            if (r_count == '0) r_status <= mpq_pkg::StEmpty;
                        default: r_count <= '0;
                    endcase
                end
                SUpRd: r_state <= SUpCmp;
                SUpCmp: begin
                    if (r_pos != '0 && mpq_pkg::comes_first(r_cur, rdata)) begin
                        r_pos <= up_pos; r_state <= SUpRd;
                    end else r_state <= SHdRd;
                end
                SRmRd: begin
                    r_pos <= '0; r_state <= SRmLast;
                end
                SRmLast: begin
                    r_cur <= rdata; r_state <= SDnL;
                end
                SDnL: begin
                    r_has_l <= l_ok; r_has_r <= r_ok; r_state <= SDnR;
                end
                SDnR: begin
                    r_left <= rdata; r_state <= SDnCmp;
                end
                SDnCmp: begin
                    if (dn_take_r) begin
                        r_pos <= r_pos_c; r_state <= SDnL;
                    end else if (dn_take_l) begin
                        r_pos <= l_pos; r_state <= SDnL;
                    end else r_state <= SHdRd;
                end
                SHdRd: r_state <= SHdWait;
                SHdWait: begin
                    o_valid <= 1'b1;
                    o_status <= r_status;
                    o_head_valid <= (r_count != '0);
                    o_head_key <= (r_count != '0) ? rdata.key : 32'd0;
                    o_head_priority <= (r_count != '0) ? rdata.prio : 32'd0;
                    r_state <= SOut;
                end
                SOut: if (i_ready) begin
                    o_valid <= 1'b0; r_state <= SIdle;
                end
                default: r_state <= SIdle;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> design/mpq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module mpq_ram #(
    parameter int Width = 8,
    parameter int Dep   = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [$clog2(Dep)-1:0] i_waddr,
    input  wire logic [Width-1:0]       i_wdata,
    input  wire logic [$clog2(Dep)-1:0] i_raddr,
    output logic      [Width-1:0]       o_rdata
);
    logic [Width-1:0] r_mem [Dep];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
